@@ hw/rtl/kdb_pkg.sv @@
// ----------------------------------------------------------------------------
// kdb_pkg: shared types and constants for the key debouncer
// Slot geometry, register indexes and the slot unit's interface structs.
// ----------------------------------------------------------------------------
package kdb_pkg;

  localparam int unsigned NumKeys    = 8;
  localparam int unsigned PinsPerKey = 3;
  localparam int unsigned SlotCount  = 24;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned KeyW       = 3;
  localparam int unsigned PinW       = 2;
  localparam int unsigned CntW       = 2;
  localparam int unsigned HoldW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 24;

  localparam logic [CntW-1:0]  CntMax  = CntW'(PinsPerKey);
  localparam logic [HoldW-1:0] HoldMax = '1;

  localparam logic [CfgIdxW-1:0] RegDebouncePolls = 2'd0;
  localparam logic [CfgIdxW-1:0] RegActiveLowMask = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSlotEnable    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegEventsEnabled = 2'd3;

  typedef struct packed {
    logic             first;
    logic             sense;
    logic             raw;
    logic             stable;
    logic [HoldW-1:0] hold;
    logic [HoldW-1:0] debounce;
    logic [CntW-1:0]  cnt;
    logic             reported;
    logic             asleep;
    logic             events_en;
  } slot_in_t;

  typedef struct packed {
    logic             raw;
    logic             stable;
    logic [HoldW-1:0] hold;
    logic [CntW-1:0]  cnt;
    logic             reported;
    logic             asleep;
    logic             evt;
    logic             evt_pressed;
  } slot_out_t;

endpackage

@@ hw/rtl/kdb_slot_unit.sv @@
// ----------------------------------------------------------------------------
// kdb_slot_unit: shared debounce update for one pin slot
// Hold count, raw/stable tracking, key press count and event decision.
// ----------------------------------------------------------------------------
module kdb_slot_unit (
  input  kdb_pkg::slot_in_t  s_i,
  output kdb_pkg::slot_out_t s_o
);

  logic changed;
  logic flip;

  always_comb begin
    s_o = '0;
    s_o.raw      = s_i.raw;
    s_o.stable   = s_i.stable;
    s_o.hold     = s_i.hold;
    s_o.cnt      = s_i.cnt;
    s_o.reported = s_i.reported;
    s_o.asleep   = s_i.asleep;
    s_o.evt_pressed = s_i.sense;
    changed = 1'b0;
    flip    = 1'b0;
    if (s_i.first) begin
      s_o.raw    = s_i.sense;
      s_o.stable = s_i.sense;
      s_o.hold   = '0;
      if (s_i.sense && s_i.cnt < kdb_pkg::CntMax) s_o.cnt = s_i.cnt + 1'b1;
    end else begin
      changed = s_i.sense != s_i.raw;
      if (changed) begin
        s_o.raw  = s_i.sense;
        s_o.hold = '0;
      end else if (s_i.hold != kdb_pkg::HoldMax) begin
        s_o.hold = s_i.hold + 1'b1;
      end
      flip = (s_i.sense != s_i.stable) && (s_o.hold >= s_i.debounce);
      if (flip) begin
        s_o.stable = s_i.sense;
        if (s_i.sense) begin
          if (s_i.cnt < kdb_pkg::CntMax) begin
            s_o.cnt = s_i.cnt + 1'b1;
            if (s_i.cnt == '0) begin
              s_o.asleep   = 1'b0;
              s_o.reported = !s_i.asleep && s_i.events_en;
              s_o.evt      = !s_i.asleep && s_i.events_en;
            end
          end
        end else if (s_i.cnt != '0) begin
          s_o.cnt = s_i.cnt - 1'b1;
          if (s_i.cnt == kdb_pkg::CntW'(1)) begin
            s_o.evt      = s_i.reported;
            s_o.reported = 1'b0;
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/multi_input_key_debouncer_top.sv @@
// ----------------------------------------------------------------------------
// multi_input_key_debouncer_top: multi-pin key debouncer
// Walks the pin slots of each poll tick through one shared slot unit.
//
// Usage:
//   Input channel: one beat per poll tick (raw_levels_i, screen_asleep_i),
//   valid/stall. in_stall_o is high while a tick is being processed.
//   Output channel: one beat per key press/release event, in key then pin
//   order; last_event_o marks the final event of a tick. A tick with no
//   events produces no beat.
//   Timing: an accepted tick holds in_stall_o high while the walk visits all
//   24 slots and the flush state, so a new tick is taken only in idle.
//   An event that waits on a stalled receiver lengthens the walk.
//   Stall: the walk pauses on a slot whose event cannot yet be buffered; no
//   event is dropped.
//   Reset: debounce_polls = 3, masks and events_enabled cleared, all slot
//   state zero; the first tick after reset only loads pin states.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i; write
//   only while the block is idle.
// ----------------------------------------------------------------------------
module multi_input_key_debouncer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kdb_pkg::SlotCount-1:0] raw_levels_i,
  input  logic                          screen_asleep_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kdb_pkg::KeyW-1:0]      key_index_o,
  output logic                          key_pressed_o,
  output logic                          last_event_o,
  input  logic                          cfg_we_i,
  input  logic [kdb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kdb_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  localparam logic [kdb_pkg::SlotW-1:0] LastSlot = kdb_pkg::SlotW'(kdb_pkg::SlotCount - 1);
  localparam logic [kdb_pkg::PinW-1:0]  LastPin  = kdb_pkg::PinW'(kdb_pkg::PinsPerKey - 1);

  logic [kdb_pkg::HoldW-1:0]     debounce_q;
  logic [kdb_pkg::SlotCount-1:0] active_low_q, enable_q;
  logic                          events_en_q;

  logic [1:0]                    state_q, state_d;
  logic [kdb_pkg::SlotW-1:0]     slot_q;
  logic [kdb_pkg::KeyW-1:0]      key_q;
  logic [kdb_pkg::PinW-1:0]      pin_q;
  logic                          first_q;
  logic                          asleep_q;
  logic [kdb_pkg::SlotCount-1:0] sense_q;

  logic [kdb_pkg::SlotCount-1:0] raw_q, stable_q;
  logic [kdb_pkg::HoldW-1:0]     hold_q [kdb_pkg::SlotCount];
  logic [kdb_pkg::CntW-1:0]      cnt_q [kdb_pkg::NumKeys];
  logic [kdb_pkg::NumKeys-1:0]   rep_q;

  logic                          pend_valid_q;
  logic [kdb_pkg::KeyW-1:0]      pend_key_q;
  logic                          pend_pressed_q;

  logic                          out_valid_q;
  logic [kdb_pkg::KeyW-1:0]      out_key_q;
  logic                          out_pressed_q;
  logic                          out_last_q;

  kdb_pkg::slot_in_t             su_in;
  kdb_pkg::slot_out_t            su_out;

  logic in_acc;
  logic out_free;
  logic slot_en;
  logic commit;
  logic push;
  logic push_last;

  assign in_stall_o = state_q != StIdle;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign slot_en    = enable_q[slot_q];

  always_comb begin
    su_in.first     = first_q;
    su_in.sense     = sense_q[slot_q];
    su_in.raw       = raw_q[slot_q];
    su_in.stable    = stable_q[slot_q];
    su_in.hold      = hold_q[slot_q];
    su_in.debounce  = debounce_q;
    su_in.cnt       = cnt_q[key_q];
    su_in.reported  = rep_q[key_q];
    su_in.asleep    = asleep_q;
    su_in.events_en = events_en_q;
  end

  kdb_slot_unit u_slot (
    .s_i(su_in),
    .s_o(su_out)
  );

  always_comb begin
    commit    = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    state_d   = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = StWalk;
      end
      StWalk: begin
        commit = !(slot_en && su_out.evt && pend_valid_q && !out_free);
        push   = commit && slot_en && su_out.evt && pend_valid_q;
        if (commit && slot_q == LastSlot) state_d = StFlush;
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= 8'd3;
      active_low_q <= '0;
      enable_q     <= '0;
      events_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kdb_pkg::RegDebouncePolls: debounce_q   <= cfg_data_i[kdb_pkg::HoldW-1:0];
        kdb_pkg::RegActiveLowMask: active_low_q <= cfg_data_i;
        kdb_pkg::RegSlotEnable:    enable_q     <= cfg_data_i;
        kdb_pkg::RegEventsEnabled: events_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      slot_q       <= '0;
      key_q        <= '0;
      pin_q        <= '0;
      first_q      <= 1'b1;
      asleep_q     <= 1'b0;
      sense_q      <= '0;
      raw_q        <= '0;
      stable_q     <= '0;
      rep_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_key_q   <= '0;
      pend_pressed_q <= 1'b0;
      for (int i = 0; i < kdb_pkg::SlotCount; i++) hold_q[i] <= '0;
      for (int k = 0; k < kdb_pkg::NumKeys; k++) cnt_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        sense_q  <= raw_levels_i ^ active_low_q;
        asleep_q <= screen_asleep_i;
        slot_q   <= '0;
        key_q    <= '0;
        pin_q    <= '0;
      end
      if (commit) begin
        if (slot_en) begin
          raw_q[slot_q]    <= su_out.raw;
          stable_q[slot_q] <= su_out.stable;
          hold_q[slot_q]   <= su_out.hold;
          cnt_q[key_q]     <= su_out.cnt;
          rep_q[key_q]     <= su_out.reported;
          asleep_q         <= su_out.asleep;
          if (su_out.evt) begin
            pend_valid_q   <= 1'b1;
            pend_key_q     <= key_q;
            pend_pressed_q <= su_out.evt_pressed;
          end
        end
        slot_q <= slot_q + 1'b1;
        if (pin_q == LastPin) begin
          pin_q <= '0;
          key_q <= key_q + 1'b1;
        end else begin
          pin_q <= pin_q + 1'b1;
        end
      end
      if (state_q == StFlush) begin
        first_q <= 1'b0;
        if (push) pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_key_q     <= pend_key_q;
      out_pressed_q <= pend_pressed_q;
      out_last_q    <= push_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_index_o   = out_key_q;
  assign key_pressed_o = out_pressed_q;
  assign last_event_o  = out_last_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("pending event left over in idle");

  a_first_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush && state_d == StIdle) |=> !first_q)
    else $error("first-tick flag not cleared after a tick");

  a_last_only_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_last) |-> (state_q == StFlush))
    else $error("final event beat outside of flush");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("event beat pushed over an unaccepted beat");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (slot_q <= LastSlot))
    else $error("slot counter past the last slot");

endmodule

@@ bench/multi_input_key_debouncer_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_input_key_debouncer_top_test: self-checking bench for the key debouncer
// Drives poll ticks through the valid/stall input channel under several
// register settings. A behavioral debouncer predicts the press/release events
// of each accepted tick, and every output beat is checked against them in order.
// ----------------------------------------------------------------------------
module multi_input_key_debouncer_top_test;

  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned WatchdogLimit = 5000;

  typedef struct packed {
    logic [kdb_pkg::SlotCount-1:0] levels;
    logic                          asleep;
  } poll_tick_t;

  typedef struct packed {
    logic [kdb_pkg::KeyW-1:0] key;
    logic                     pressed;
    logic                     is_last;
  } key_event_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [kdb_pkg::SlotCount-1:0] raw_levels_i    = '0;
  logic                          screen_asleep_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic [kdb_pkg::KeyW-1:0]      key_index_o;
  logic                          key_pressed_o;
  logic                          last_event_o;
  logic                          cfg_we_i        = 1'b0;
  logic [kdb_pkg::CfgIdxW-1:0]   cfg_index_i     = '0;
  logic [kdb_pkg::CfgDataW-1:0]  cfg_data_i      = '0;

  multi_input_key_debouncer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_levels_i   (raw_levels_i),
    .screen_asleep_i(screen_asleep_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_index_o    (key_index_o),
    .key_pressed_o  (key_pressed_o),
    .last_event_o   (last_event_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // debouncer state mirror
  logic [kdb_pkg::HoldW-1:0]     polls_needed     = 8'd3;
  logic [kdb_pkg::SlotCount-1:0] low_active_mask  = '0;
  logic [kdb_pkg::SlotCount-1:0] slot_enabled     = '0;
  logic                          events_on        = 1'b0;
  logic [kdb_pkg::SlotCount-1:0] pin_raw          = '0;
  logic [kdb_pkg::SlotCount-1:0] pin_stable       = '0;
  logic [kdb_pkg::HoldW-1:0]     pin_hold[kdb_pkg::SlotCount];
  logic [kdb_pkg::CntW-1:0]      key_pin_count[kdb_pkg::NumKeys];
  logic                          key_reported[kdb_pkg::NumKeys];
  logic                          awaiting_first_tick = 1'b1;

  poll_tick_t                    pending_ticks[$];
  key_event_t                    key_events_due[$];
  logic [kdb_pkg::SlotCount-1:0] held_levels   = '0;
  logic                          tick_taken    = 1'b0;
  int                            send_gap_pct  = 0;
  int                            stall_pct     = 0;
  int                            ticks_queued   = 0;
  int                            ticks_accepted = 0;
  int                            events_checked = 0;
  int                            reg_writes     = 0;
  int                            mismatches     = 0;
  int                            quiet_cycles   = 0;

  initial begin
    foreach (pin_hold[s]) pin_hold[s] = '0;
    foreach (key_pin_count[k]) begin
      key_pin_count[k] = '0;
      key_reported[k]  = 1'b0;
    end
  end

  function automatic void debounce_tick(input logic [kdb_pkg::SlotCount-1:0] levels,
                                        input logic asleep_in);
    logic [kdb_pkg::SlotCount-1:0] sense;
    logic                          asleep;
    logic                          pressed;
    int unsigned                   slot;
    key_event_t                    tick_events[$];
    sense  = levels ^ low_active_mask;
    asleep = asleep_in;
    for (int unsigned k = 0; k < kdb_pkg::NumKeys; k++) begin
      for (int unsigned p = 0; p < kdb_pkg::PinsPerKey; p++) begin
        slot = k * kdb_pkg::PinsPerKey + p;
        if (slot >= kdb_pkg::SlotCount || !slot_enabled[slot]) continue;
        pressed = sense[slot];
        if (awaiting_first_tick) begin
          pin_raw[slot]    = pressed;
          pin_stable[slot] = pressed;
          pin_hold[slot]   = '0;
          if (pressed && key_pin_count[k] < kdb_pkg::CntMax) key_pin_count[k]++;
          continue;
        end
        if (pressed != pin_raw[slot]) begin
          pin_raw[slot]  = pressed;
          pin_hold[slot] = '0;
        end else if (pin_hold[slot] != kdb_pkg::HoldMax) begin
          pin_hold[slot]++;
        end
        if (pressed == pin_stable[slot] || pin_hold[slot] < polls_needed) continue;
        pin_stable[slot] = pressed;
        if (pressed) begin
          if (key_pin_count[k] < kdb_pkg::CntMax) begin
            key_pin_count[k]++;
            if (key_pin_count[k] == 1) begin
              // a sleeping screen swallows the first press of the tick
              key_reported[k] = !asleep && events_on;
              asleep = 1'b0;
              if (key_reported[k])
                tick_events.push_back('{kdb_pkg::KeyW'(k), 1'b1, 1'b0});
            end
          end
        end else if (key_pin_count[k] != 0) begin
          key_pin_count[k]--;
          if (key_pin_count[k] == 0) begin
            if (key_reported[k])
              tick_events.push_back('{kdb_pkg::KeyW'(k), 1'b0, 1'b0});
            key_reported[k] = 1'b0;
          end
        end
      end
    end
    awaiting_first_tick = 1'b0;
    if (tick_events.size() != 0) tick_events[$].is_last = 1'b1;
    foreach (tick_events[i]) key_events_due.push_back(tick_events[i]);
  endfunction

  always @(negedge clk_i) begin : drive_ticks
    poll_tick_t next_tick;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && (!in_valid_i || tick_taken)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_tick       = pending_ticks.pop_front();
        raw_levels_i    <= next_tick.levels;
        screen_asleep_i <= next_tick.asleep;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_events
    key_event_t due;
    tick_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        reg_writes++;
        case (cfg_index_i)
          kdb_pkg::RegDebouncePolls: polls_needed    = cfg_data_i[kdb_pkg::HoldW-1:0];
          kdb_pkg::RegActiveLowMask: low_active_mask = cfg_data_i[kdb_pkg::SlotCount-1:0];
          kdb_pkg::RegSlotEnable:    slot_enabled    = cfg_data_i[kdb_pkg::SlotCount-1:0];
          kdb_pkg::RegEventsEnabled: events_on       = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        events_checked++;
        if (key_events_due.size() == 0) begin
          $error("key event with none expected: key_index %0d key_pressed %0b",
                 key_index_o, key_pressed_o);
          mismatches++;
        end else begin
          due = key_events_due.pop_front();
          if (key_index_o !== due.key) begin
            $error("key_index: expected %0d, got %0d", due.key, key_index_o);
            mismatches++;
          end
          if (key_pressed_o !== due.pressed) begin
            $error("key_pressed: expected %0b, got %0b", due.pressed, key_pressed_o);
            mismatches++;
          end
          if (last_event_o !== due.is_last) begin
            $error("last_event: expected %0b, got %0b", due.is_last, last_event_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ticks_accepted++;
        debounce_tick(raw_levels_i, screen_asleep_i);
      end
      if (cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == WatchdogLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [kdb_pkg::CfgIdxW-1:0] index,
                           input logic [kdb_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_tick(input logic [kdb_pkg::SlotCount-1:0] levels, input logic asleep);
    pending_ticks.push_back('{levels, asleep});
    ticks_queued++;
  endtask

  // sender holds off until all beats are out and the walk is done
  task automatic wait_idle();
    do @(negedge clk_i);
    while (ticks_accepted != ticks_queued || key_events_due.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // mostly held levels with occasional changes; glitches and noise mixed in
  task automatic random_ticks(input int count);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_tick(held_levels, $urandom_range(99) < 15);
      end else if (pick < 55) begin
        queue_tick(held_levels ^ (kdb_pkg::SlotCount'(1)
                                  << $urandom_range(kdb_pkg::SlotCount - 1)),
                   $urandom_range(99) < 15);
      end else begin
        if (pick < 80)
          held_levels ^= kdb_pkg::SlotCount'(1) << $urandom_range(kdb_pkg::SlotCount - 1);
        else if (pick < 94)
          held_levels ^= kdb_pkg::SlotCount'($urandom) & kdb_pkg::SlotCount'($urandom);
        else
          held_levels = kdb_pkg::SlotCount'($urandom);
        queue_tick(held_levels, $urandom_range(99) < 15);
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_gap_pct = 23;
    stall_pct    = 76;

    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(0));
    write_reg(kdb_pkg::RegActiveLowMask, 24'h000000);
    write_reg(kdb_pkg::RegSlotEnable,    24'hFFFFFF);
    write_reg(kdb_pkg::RegEventsEnabled, kdb_pkg::CfgDataW'(1));
    queue_tick(24'hFFFFFF, 1'b0);   // first tick only loads
    queue_tick(24'h000000, 1'b0);
    queue_tick(24'hFFFFFF, 1'b1);
    queue_tick(24'h000000, 1'b0);
    queue_tick(24'h924924, 1'b0);
    queue_tick(24'hB6DB6D, 1'b0);
    queue_tick(24'h249249, 1'b0);
    queue_tick(24'h000000, 1'b0);
    queue_tick(24'h000001, 1'b1);
    queue_tick(24'h000000, 1'b1);
    queue_tick(24'h800000, 1'b0);
    queue_tick(24'h000000, 1'b0);
    wait_idle();

    write_reg(kdb_pkg::RegEventsEnabled, kdb_pkg::CfgDataW'(0));
    queue_tick(24'h000007, 1'b0);
    queue_tick(24'h00003F, 1'b1);
    wait_idle();

    write_reg(kdb_pkg::RegEventsEnabled, kdb_pkg::CfgDataW'(1));
    queue_tick(24'h000000, 1'b0);
    queue_tick(24'h000007, 1'b0);
    wait_idle();

    write_reg(kdb_pkg::RegActiveLowMask, 24'hFFFFFF);
    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(2));
    repeat (3) queue_tick(24'h000007, 1'b0);
    repeat (3) queue_tick(24'hFFFFFF, 1'b0);
    wait_idle();

    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(1));
    write_reg(kdb_pkg::RegActiveLowMask, kdb_pkg::CfgDataW'($urandom));
    write_reg(kdb_pkg::RegSlotEnable,    24'hFFFFFF);
    random_ticks(45);
    wait_idle();

    send_gap_pct = 76;
    stall_pct    = 23;
    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(3));
    write_reg(kdb_pkg::RegActiveLowMask, 24'hFFFFFF);
    write_reg(kdb_pkg::RegSlotEnable,    kdb_pkg::CfgDataW'($urandom));
    random_ticks(45);
    wait_idle();

    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(2));
    write_reg(kdb_pkg::RegActiveLowMask, 24'h000000);
    write_reg(kdb_pkg::RegEventsEnabled, kdb_pkg::CfgDataW'(0));
    random_ticks(20);
    wait_idle();

    send_gap_pct = 0;
    stall_pct    = 0;
    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(0));
    write_reg(kdb_pkg::RegActiveLowMask, kdb_pkg::CfgDataW'($urandom));
    write_reg(kdb_pkg::RegSlotEnable,    kdb_pkg::CfgDataW'($urandom));
    write_reg(kdb_pkg::RegEventsEnabled, kdb_pkg::CfgDataW'(1));
    random_ticks(45);
    wait_idle();

    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(255));
    random_ticks(15);
    wait_idle();

    write_reg(kdb_pkg::RegDebouncePolls, kdb_pkg::CfgDataW'(1));
    write_reg(kdb_pkg::RegActiveLowMask, 24'h000000);
    write_reg(kdb_pkg::RegSlotEnable,    24'hFFFFFF);
    random_ticks(30);
    wait_idle();

    $display("Covered %0d poll ticks and %0d key event beats over %0d register writes,",
             ticks_accepted, events_checked, reg_writes);
    $display("with debounce from 0 to 255, both pin polarities, partial slot maps and sleep.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/kdb_pkg.sv
hw/rtl/kdb_slot_unit.sv
hw/rtl/multi_input_key_debouncer_top.sv
bench/multi_input_key_debouncer_top_test.sv
